@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the interrupt controller checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/pic8259_pkg.sv @@
// ---------------------------------------------------------------------------
// pic8259_pkg
// Types, command codes and the rotating priority finder of the controller.
// ---------------------------------------------------------------------------
package pic8259_pkg;

  localparam int unsigned NumLines = 8;
  localparam int unsigned LineW    = 3;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CmdW     = 3;

  // Stream word widths
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 16;

  // Write decode patterns
  localparam logic [ByteW-1:0] Icw1Bit    = 8'h10;
  localparam logic [ByteW-1:0] OcwSelMask = 8'h18;
  localparam logic [ByteW-1:0] Ocw3Mask   = 8'h98;
  localparam logic [ByteW-1:0] Ocw3Code   = 8'h08;
  localparam logic [ByteW-1:0] MaskReset  = 8'hff;
  localparam logic [ByteW-1:0] VecMask    = 8'hf8;

  typedef enum logic [CmdW-1:0] {
    CMD_LINE  = 3'd0,
    CMD_WRITE = 3'd1,
    CMD_READ  = 3'd2,
    CMD_ACK   = 3'd3,
    CMD_TICK  = 3'd4
  } cmd_e;

  // OCW2 command field, bits 7:5
  typedef enum logic [2:0] {
    OCW2_AEOI_ROT_CLR = 3'd0,
    OCW2_EOI          = 3'd1,
    OCW2_NOP          = 3'd2,
    OCW2_SPEC_EOI     = 3'd3,
    OCW2_AEOI_ROT_SET = 3'd4,
    OCW2_ROT_EOI      = 3'd5,
    OCW2_SET_PRIO     = 3'd6,
    OCW2_ROT_SPEC_EOI = 3'd7
  } ocw2_e;

  typedef enum logic [1:0] {
    INIT_DONE = 2'd0,
    INIT_ICW2 = 2'd1,
    INIT_ICW3 = 2'd2,
    INIT_ICW4 = 2'd3
  } init_step_e;

  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic [LineW-1:0] irq_line;
    logic [ByteW-1:0] data;
    logic             reg_addr;
  } in_item_t;

  typedef struct packed {
    logic [ByteW-1:0] read_data;
    logic             intr;
    logic             no_request;
  } result_t;

  typedef struct packed {
    logic             found;
    logic [LineW-1:0] rank;   // distance from the priority base
    logic [LineW-1:0] line;   // absolute line number
  } prio_t;

  // Find the highest-priority set bit, counting from the rotating base.
  function automatic prio_t prio_find(logic [NumLines-1:0] bits,
                                      logic [LineW-1:0] base);
    logic [2*NumLines-1:0] dbl;
    logic [NumLines-1:0]   rot;
    prio_t                 res;
    dbl = {bits, bits} >> base;
    rot = dbl[NumLines-1:0];
    res = '0;
    for (int k = NumLines - 1; k >= 0; k--) begin
      if (rot[k]) begin
        res.found = 1'b1;
        res.rank  = LineW'(k);
      end
    end
    res.line = base + res.rank;
    return res;
  endfunction

endpackage

@@ hdl/interrupt_controller_8259.sv @@
// Path: an accepted word is held in the input register until the result slot is free
// or drains, and its result word is then captured in the result register.
// Throughput: one word per cycle while the result side takes words; each word is
// processed combinationally between the input register and the result register.
// Backpressure: the input stalls only while both registers hold words.
// Reset: asynchronous, active low; mask all ones, request read selected,
// every other core state register and both stream valid flags cleared.
// ---------------------------------------------------------------------------
// interrupt_controller_8259
// Eight-line edge-triggered interrupt controller with stream ports.
// ---------------------------------------------------------------------------
module interrupt_controller_8259 (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // tdata: irq_line[2:0], data[10:3], reg_addr[11], zero fill [15:12]
  input  logic [pic8259_pkg::InDataW-1:0]     s_axis_tdata_i,
  // tuser: command[2:0]
  input  logic [pic8259_pkg::CmdW-1:0]        s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // tdata: read_data[7:0], intr[8], no_request[9], zero fill [15:10]
  output logic [pic8259_pkg::OutDataW-1:0]    m_axis_tdata_o
);
  import pic8259_pkg::*;

  logic     in_valid_q, in_valid_d;
  in_item_t in_q;
  logic     out_valid_q, out_valid_d;
  result_t  out_q;
  result_t  core_res;
  logic     advance, s_accept, step_en;

  // Move the held word on whenever the result slot is free or drains
  assign advance         = !out_valid_q || m_axis_tready_i;
  assign step_en         = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept)     in_valid_d = 1'b1;
    else if (advance) in_valid_d = 1'b0;
    out_valid_d = advance ? in_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the input word
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_q.command  <= s_axis_tuser_i;
      in_q.irq_line <= s_axis_tdata_i[2:0];
      in_q.data     <= s_axis_tdata_i[10:3];
      in_q.reg_addr <= s_axis_tdata_i[11];
    end
  end

  pic8259_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (step_en),
    .item_i    (in_q),
    .result_o  (core_res)
  );

  // Hold the result word
  always_ff @(posedge clk_i) begin
    if (step_en) out_q <= core_res;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, out_q.no_request, out_q.intr, out_q.read_data};

endmodule

@@ hdl/pic8259_core.sv @@
// ---------------------------------------------------------------------------
// pic8259_core
// Controller state and the combinational processing of one command word.
// ---------------------------------------------------------------------------
module pic8259_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_en_i,
  input  pic8259_pkg::in_item_t item_i,
  output pic8259_pkg::result_t  result_o
);
  import pic8259_pkg::*;

  logic [1:0]       icw1_q, icw1_d;        // bit1 single, bit0 ICW4 needed
  logic             auto_eoi_q, auto_eoi_d; // ICW4 bit1
  logic [ByteW-1:0] vec_base_q, vec_base_d;
  init_step_e       step_q, step_d;
  logic             read_irr_q, read_irr_d;
  logic [ByteW-1:0] irr_q, irr_d;
  logic [ByteW-1:0] imr_q, imr_d;
  logic [ByteW-1:0] isr_q, isr_d;
  logic [ByteW-1:0] level_q, level_d;
  logic [LineW-1:0] prio_q, prio_d;
  logic             rot_q, rot_d;
  logic             intr_q, intr_d;

  prio_t            req_win, isr_top, isr_msk;
  logic [ByteW-1:0] line_bit, win_bit, top_bit, spec_bit;
  logic [ByteW-1:0] wdata;
  result_t          res;

  assign wdata    = item_i.data;
  assign req_win  = prio_find(irr_q & ~imr_q, prio_q);
  assign isr_top  = prio_find(isr_q, prio_q);
  assign isr_msk  = prio_find(isr_q & ~imr_q, prio_q);
  assign line_bit = ByteW'(1) << item_i.irq_line;
  assign win_bit  = ByteW'(1) << req_win.line;
  assign top_bit  = ByteW'(1) << isr_top.line;
  assign spec_bit = ByteW'(1) << wdata[2:0];

  // Compute next state and the result word
  always_comb begin
    icw1_d     = icw1_q;
    auto_eoi_d = auto_eoi_q;
    vec_base_d = vec_base_q;
    step_d     = step_q;
    read_irr_d = read_irr_q;
    irr_d      = irr_q;
    imr_d      = imr_q;
    isr_d      = isr_q;
    level_d    = level_q;
    prio_d     = prio_q;
    rot_d      = rot_q;
    intr_d     = intr_q;
    res        = '0;

    case (item_i.command)
      CMD_LINE: begin
        if (wdata == '0) begin
          level_d = level_q & ~line_bit;
        end else begin
          if ((level_q & line_bit) == '0) begin
            irr_d = irr_q | line_bit;
          end
          level_d = level_q | line_bit;
        end
      end
      CMD_WRITE: begin
        if (!item_i.reg_addr) begin
          if ((wdata & Icw1Bit) != '0) begin
            // ICW1: restart the init sequence
            icw1_d     = wdata[1:0];
            auto_eoi_d = 1'b0;
            vec_base_d = '0;
            level_d    = '0;
            step_d     = INIT_ICW2;
            read_irr_d = 1'b1;
            prio_d     = '0;
            rot_d      = 1'b0;
            irr_d      = '0;
            imr_d      = MaskReset;
            isr_d      = '0;
          end else if ((wdata & OcwSelMask) == '0) begin
            // OCW2: EOI and rotation
            case (ocw2_e'(wdata[7:5]))
              OCW2_AEOI_ROT_CLR: rot_d = 1'b0;
              OCW2_EOI: begin
                if (isr_top.found) isr_d = isr_q & ~top_bit;
              end
              OCW2_NOP: ;
              OCW2_SPEC_EOI: isr_d = isr_q & ~spec_bit;
              OCW2_AEOI_ROT_SET: rot_d = 1'b1;
              OCW2_ROT_EOI: begin
                if (isr_top.found) begin
                  isr_d  = isr_q & ~top_bit;
                  prio_d = isr_top.line + LineW'(1);
                end
              end
              OCW2_SET_PRIO: prio_d = wdata[2:0] + LineW'(1);
              OCW2_ROT_SPEC_EOI: begin
                isr_d  = isr_q & ~spec_bit;
                prio_d = wdata[2:0] + LineW'(1);
              end
              default: ;
            endcase
          end else if ((wdata & Ocw3Mask) == Ocw3Code) begin
            // OCW3: read select
            if (wdata[1]) read_irr_d = ~wdata[0];
          end
        end else begin
          case (step_q)
            INIT_ICW2: begin
              vec_base_d = wdata & VecMask;
              if (!icw1_q[1])     step_d = INIT_ICW3;
              else if (icw1_q[0]) step_d = INIT_ICW4;
              else                step_d = INIT_DONE;
            end
            INIT_ICW3: step_d = icw1_q[0] ? INIT_ICW4 : INIT_DONE;
            INIT_ICW4: begin
              auto_eoi_d = wdata[1];
              step_d     = INIT_DONE;
            end
            default: imr_d = wdata;
          endcase
        end
      end
      CMD_READ: begin
        if (!item_i.reg_addr) res.read_data = read_irr_q ? irr_q : isr_q;
        else                  res.read_data = imr_q;
      end
      CMD_ACK: begin
        intr_d = 1'b0;
        if (!req_win.found) begin
          res.no_request = 1'b1;
          res.read_data  = vec_base_q + ByteW'(NumLines - 1);
        end else begin
          irr_d = irr_q & ~win_bit;
          if (auto_eoi_q) begin
            if (rot_q) prio_d = req_win.line + LineW'(1);
          end else begin
            isr_d = isr_q | win_bit;
          end
          res.read_data = vec_base_q + ByteW'(req_win.line);
        end
      end
      CMD_TICK: begin
        if (irr_q != '0 && req_win.found &&
            (!isr_msk.found || req_win.rank < isr_msk.rank)) begin
          intr_d = 1'b1;
        end
      end
      default: ;
    endcase

    res.intr = intr_d;
  end

  assign result_o = res;

  // Commit state on each processed word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      icw1_q     <= '0;
      auto_eoi_q <= 1'b0;
      vec_base_q <= '0;
      step_q     <= INIT_DONE;
      read_irr_q <= 1'b1;
      irr_q      <= '0;
      imr_q      <= MaskReset;
      isr_q      <= '0;
      level_q    <= '0;
      prio_q     <= '0;
      rot_q      <= 1'b0;
      intr_q     <= 1'b0;
    end else if (step_en_i) begin
      icw1_q     <= icw1_d;
      auto_eoi_q <= auto_eoi_d;
      vec_base_q <= vec_base_d;
      step_q     <= step_d;
      read_irr_q <= read_irr_d;
      irr_q      <= irr_d;
      imr_q      <= imr_d;
      isr_q      <= isr_d;
      level_q    <= level_d;
      prio_q     <= prio_d;
      rot_q      <= rot_d;
      intr_q     <= intr_d;
    end
  end

endmodule

@@ hdl/pic8259_checker.sv @@
// ---------------------------------------------------------------------------
// pic8259_checker
// Port-level checks of the interrupt controller, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pic8259_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tready_o,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [pic8259_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import pic8259_pkg::*;

  logic                out_vld;
  logic                noreq;
  logic                out_intr;
  logic [2:0]          vec_lo;
  logic                out_stall;
  logic [OutDataW-1:0] out_word;

  // Split the result word into the fields under check
  assign out_vld   = m_axis_tvalid_o;
  assign noreq     = m_axis_tvalid_o && m_axis_tdata_o[9];
  assign out_intr  = m_axis_tdata_o[8];
  assign vec_lo    = m_axis_tdata_o[2:0];
  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign out_word  = m_axis_tdata_o;

  // A failed acknowledge always drops the processor request
  `CHK_IMPLY(a_noreq_intr_low, clk_i, rst_ni, noreq, !out_intr, "no_request with intr high")

  // A failed acknowledge returns the base plus seven
  `CHK_IMPLY(a_noreq_vector, clk_i, rst_ni, noreq, vec_lo == 3'd7, "vector not base+7")

  // The input stalls only behind a full result slot
  `CHK_IMPLY(a_stall_cause, clk_i, rst_ni, !s_axis_tready_o, out_vld, "stall, output empty")

  // A stalled result word holds
  `CHK_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_vld && $stable(out_word), "word changed")

endmodule

bind interrupt_controller_8259 pic8259_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Stream-level testbench of the eight-line interrupt controller. A queue of
// command words (line changes, register writes, reads, acknowledges, ticks)
// feeds a clocked driver. The driver runs a local model of the controller
// on every accepted word and queues the result it must produce. A clocked
// monitor compares each result word, field by field, against that queue
// while both sides idle and stall in changing patterns.
// ---------------------------------------------------------------------------
module tb_top;
  import pic8259_pkg::*;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned TailCycles    = 8;
  localparam int unsigned RandomWords   = 1500;

  typedef struct {
    in_item_t item;
    bit       drain;   // hold this word back until all results are in
  } pending_t;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i  = '0;
  logic [CmdW-1:0]     s_axis_tuser_i  = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;

  pending_t    pending_words [$];
  result_t     expected_results [$];
  logic [31:0] words_in    = '0;
  int unsigned fail_count  = 0;
  int unsigned idle_cycles = 0;

  // Idle pattern changes every 128 accepted words
  logic [1:0]  phase;
  int unsigned send_idle_pct [4] = '{0, 60, 0, 29};
  int unsigned recv_stall_pct [4] = '{0, 0, 60, 29};
  assign phase = words_in[8:7];

  // Model state of the controller
  logic [7:0]  icw [4];
  logic [7:0]  vec_base;
  init_step_e  init_pos;
  logic        sel_irr;
  logic [7:0]  irr;
  logic [7:0]  imr;
  logic [7:0]  isr;
  logic [7:0]  levels;
  logic [2:0]  pbase;
  logic        rot_aeoi;
  logic        intr_q;

  interrupt_controller_8259 dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #1 clk_i = ~clk_i;

  // Distance from the priority base to the first set bit; 8 when none is set
  function automatic int unsigned rank_from_base(logic [7:0] bits, logic [2:0] base);
    logic [2:0] pos;
    for (int k = 0; k < 8; k++) begin
      pos = base + 3'(k);
      if (bits[pos]) return k;
    end
    return 8;
  endfunction

  task automatic reset_model();
    for (int i = 0; i < 4; i++) icw[i] = '0;
    vec_base = '0;
    init_pos = INIT_DONE;
    sel_irr  = 1'b1;
    irr      = '0;
    imr      = MaskReset;
    isr      = '0;
    levels   = '0;
    pbase    = '0;
    rot_aeoi = 1'b0;
    intr_q   = 1'b0;
  endtask

  // EOI and rotation commands
  task automatic apply_ocw2(logic [7:0] d);
    int unsigned top_rank;
    logic [2:0]  top_line;
    logic [7:0]  top_bit;
    logic [7:0]  spec_bit;
    top_rank = rank_from_base(isr, pbase);
    top_line = pbase + 3'(top_rank);
    top_bit  = 8'(1) << top_line;
    spec_bit = 8'(1) << d[2:0];
    case (ocw2_e'(d[7:5]))
      OCW2_AEOI_ROT_CLR: rot_aeoi = 1'b0;
      OCW2_EOI: if (top_rank < 8) isr &= ~top_bit;
      OCW2_NOP: ;
      OCW2_SPEC_EOI: isr &= ~spec_bit;
      OCW2_AEOI_ROT_SET: rot_aeoi = 1'b1;
      OCW2_ROT_EOI: begin
        if (top_rank < 8) begin
          isr  &= ~top_bit;
          pbase = top_line + 3'd1;
        end
      end
      OCW2_SET_PRIO: pbase = d[2:0] + 3'd1;
      default: begin
        isr  &= ~spec_bit;
        pbase = d[2:0] + 3'd1;
      end
    endcase
  endtask

  task automatic apply_write(logic addr, logic [7:0] d);
    if (!addr) begin
      if ((d & Icw1Bit) == Icw1Bit) begin
        icw[0]   = d;
        icw[1]   = '0;
        icw[2]   = '0;
        icw[3]   = '0;
        vec_base = '0;
        levels   = '0;
        init_pos = INIT_ICW2;
        sel_irr  = 1'b1;
        pbase    = '0;
        rot_aeoi = 1'b0;
        irr      = '0;
        imr      = MaskReset;
        isr      = '0;
      end else if ((d & OcwSelMask) == 8'h00) begin
        apply_ocw2(d);
      end else if ((d & Ocw3Mask) == Ocw3Code) begin
        if (d[1]) sel_irr = ~d[0];
      end
    end else begin
      case (init_pos)
        INIT_ICW2: begin
          icw[1]   = d;
          vec_base = d & VecMask;
          if (!icw[0][1]) init_pos = INIT_ICW3;
          else if (icw[0][0]) init_pos = INIT_ICW4;
          else init_pos = INIT_DONE;
        end
        INIT_ICW3: begin
          icw[2]   = d;
          init_pos = icw[0][0] ? INIT_ICW4 : INIT_DONE;
        end
        INIT_ICW4: begin
          icw[3]   = d;
          init_pos = INIT_DONE;
        end
        default: imr = d;
      endcase
    end
  endtask

  // Advance the model by one command word and return the result it causes
  task automatic pic_predict(in_item_t it, output result_t res);
    logic [7:0]  line_bit;
    logic [2:0]  win_line;
    int unsigned win_rank;
    int unsigned svc_rank;
    res      = '0;
    line_bit = 8'(1) << it.irq_line;
    case (it.command)
      CMD_LINE: begin
        if (it.data == 8'h00) begin
          levels &= ~line_bit;
        end else begin
          if ((levels & line_bit) == 8'h00) irr |= line_bit;
          levels |= line_bit;
        end
      end
      CMD_WRITE: apply_write(it.reg_addr, it.data);
      CMD_READ: res.read_data = it.reg_addr ? imr : (sel_irr ? irr : isr);
      CMD_ACK: begin
        intr_q   = 1'b0;
        win_rank = rank_from_base(irr & ~imr, pbase);
        if (win_rank >= 8) begin
          res.no_request = 1'b1;
          res.read_data  = vec_base + 8'd7;
        end else begin
          win_line = pbase + 3'(win_rank);
          line_bit = 8'(1) << win_line;
          irr &= ~line_bit;
          if (icw[3][1]) begin
            if (rot_aeoi) pbase = win_line + 3'd1;
          end else begin
            isr |= line_bit;
          end
          res.read_data = vec_base + 8'(win_line);
        end
      end
      CMD_TICK: begin
        if (irr != 8'h00) begin
          win_rank = rank_from_base(irr & ~imr, pbase);
          svc_rank = rank_from_base(isr & ~imr, pbase);
          if (win_rank < svc_rank) intr_q = 1'b1;
        end
      end
      default: ;
    endcase
    res.intr = intr_q;
  endtask

  task automatic push_word(logic [2:0] cmd, logic [2:0] line, logic [7:0] d,
                           logic addr, bit drain = 1'b0);
    pending_t p;
    p.item.command  = cmd;
    p.item.irq_line = line;
    p.item.data     = d;
    p.item.reg_addr = addr;
    p.drain         = drain;
    pending_words.push_back(p);
  endtask

  // Driver: predict on acceptance, then present the next word or idle
  always @(posedge clk_i or negedge rst_ni) begin : driver_proc
    in_item_t acc;
    result_t  res;
    pending_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      s_axis_tuser_i  <= '0;
    end else if (!s_axis_tvalid_i || s_axis_tready_o) begin
      if (s_axis_tvalid_i) begin
        acc.command  = s_axis_tuser_i;
        acc.irq_line = s_axis_tdata_i[2:0];
        acc.data     = s_axis_tdata_i[10:3];
        acc.reg_addr = s_axis_tdata_i[11];
        pic_predict(acc, res);
        expected_results.push_back(res);
        words_in <= words_in + 1;
      end
      if (pending_words.size() != 0 &&
          !(pending_words[0].drain && expected_results.size() != 0) &&
          $urandom_range(99) >= send_idle_pct[phase]) begin
        nxt = pending_words.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tuser_i  <= nxt.item.command;
        s_axis_tdata_i  <= {4'b0000, nxt.item.reg_addr, nxt.item.data, nxt.item.irq_line};
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // Monitor: compare each result word with the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin : monitor_proc
    result_t want;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_results.size() == 0) begin
          $error("result word %h with no expectation pending", m_axis_tdata_o);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tdata_o[7:0] !== want.read_data) begin
            $error("read_data: expected %h, got %h", want.read_data, m_axis_tdata_o[7:0]);
            fail_count++;
          end
          if (m_axis_tdata_o[8] !== want.intr) begin
            $error("intr: expected %b, got %b", want.intr, m_axis_tdata_o[8]);
            fail_count++;
          end
          if (m_axis_tdata_o[9] !== want.no_request) begin
            $error("no_request: expected %b, got %b", want.no_request, m_axis_tdata_o[9]);
            fail_count++;
          end
        end
      end
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct[phase]);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    logic [7:0]  icw1;
    logic [7:0]  d;
    int unsigned pick;
    bit          drain;

    reset_model();

    // Directed words: reads after reset, empty acknowledge and tick, undefined commands
    push_word(CMD_READ, 3'd0, 8'h00, 1'b0);
    push_word(CMD_READ, 3'd7, 8'hff, 1'b1);
    push_word(CMD_ACK, 3'd0, 8'h00, 1'b0);
    push_word(CMD_TICK, 3'd0, 8'h00, 1'b0);
    push_word(3'd5, 3'd7, 8'hff, 1'b1);
    push_word(3'd6, 3'd0, 8'h00, 1'b0);
    push_word(3'd7, 3'd5, 8'haa, 1'b1);
    // Full init sequence, top vector base, then unmask all
    push_word(CMD_WRITE, 3'd0, 8'h11, 1'b0);
    push_word(CMD_WRITE, 3'd0, 8'hff, 1'b1);
    push_word(CMD_WRITE, 3'd0, 8'h00, 1'b1);
    push_word(CMD_WRITE, 3'd0, 8'h00, 1'b1);
    push_word(CMD_WRITE, 3'd0, 8'h00, 1'b1);
    // Edges on the extreme lines, a repeated high level, service and EOI
    push_word(CMD_LINE, 3'd7, 8'hff, 1'b0);
    push_word(CMD_LINE, 3'd0, 8'h01, 1'b1);
    push_word(CMD_LINE, 3'd0, 8'h80, 1'b0);
    push_word(CMD_TICK, 3'd0, 8'h00, 1'b0);
    push_word(CMD_ACK, 3'd0, 8'h00, 1'b0);
    push_word(CMD_WRITE, 3'd0, 8'h0b, 1'b0);
    push_word(CMD_READ, 3'd0, 8'h00, 1'b0);
    push_word(CMD_WRITE, 3'd0, 8'h20, 1'b0);
    push_word(CMD_WRITE, 3'd0, 8'h20, 1'b0);
    // Poll and special mask bits, an unmatched byte, rotation commands
    push_word(CMD_WRITE, 3'd0, 8'h6c, 1'b0);
    push_word(CMD_WRITE, 3'd0, 8'h88, 1'b0);
    push_word(CMD_WRITE, 3'd0, 8'hc7, 1'b0);
    push_word(CMD_WRITE, 3'd0, 8'he3, 1'b0);
    push_word(CMD_WRITE, 3'd0, 8'ha0, 1'b0);
    // Single mode with auto-EOI and rotation
    push_word(CMD_WRITE, 3'd0, 8'h13, 1'b0);
    push_word(CMD_WRITE, 3'd0, 8'h00, 1'b1);
    push_word(CMD_WRITE, 3'd0, 8'h02, 1'b1);
    push_word(CMD_WRITE, 3'd0, 8'h00, 1'b1);
    push_word(CMD_WRITE, 3'd0, 8'h80, 1'b0);
    push_word(CMD_LINE, 3'd3, 8'h01, 1'b0);
    push_word(CMD_TICK, 3'd0, 8'h00, 1'b0);
    push_word(CMD_ACK, 3'd0, 8'h00, 1'b0);
    push_word(CMD_LINE, 3'd3, 8'h00, 1'b0);

    // Random words: mostly well-formed traffic, some noise and broken inits
    drain = 1'b1;
    while (pending_words.size() < RandomWords) begin
      pick = $urandom_range(99);
      if (pick < 26) begin
        d = $urandom_range(1) ? 8'($urandom_range(255, 1)) : 8'h00;
        push_word(CMD_LINE, 3'($urandom), d, 1'($urandom), drain);
      end else if (pick < 42) begin
        push_word(CMD_TICK, 3'($urandom), 8'($urandom), 1'($urandom), drain);
      end else if (pick < 58) begin
        push_word(CMD_ACK, 3'($urandom), 8'($urandom), 1'($urandom), drain);
      end else if (pick < 68) begin
        push_word(CMD_READ, 3'($urandom), 8'($urandom), 1'($urandom), drain);
      end else if (pick < 78) begin
        push_word(CMD_WRITE, 3'($urandom), 8'($urandom) & 8'he7, 1'b0, drain);
      end else if (pick < 83) begin
        push_word(CMD_WRITE, 3'($urandom), (8'($urandom) & 8'h67) | Ocw3Code, 1'b0, drain);
      end else if (pick < 90) begin
        push_word(CMD_WRITE, 3'($urandom), 8'($urandom) & 8'($urandom), 1'b1, drain);
      end else if (pick < 96) begin
        // Init sequence, cut short now and then
        icw1 = 8'($urandom) | Icw1Bit;
        push_word(CMD_WRITE, 3'($urandom), icw1, 1'b0, drain);
        if ($urandom_range(9) != 0) begin
          push_word(CMD_WRITE, 3'($urandom), 8'($urandom), 1'b1);
          if ($urandom_range(9) != 0) begin
            if (!icw1[1]) push_word(CMD_WRITE, 3'($urandom), 8'($urandom), 1'b1);
            if (icw1[0]) push_word(CMD_WRITE, 3'($urandom), 8'($urandom), 1'b1);
            push_word(CMD_WRITE, 3'($urandom), 8'($urandom) & 8'($urandom), 1'b1);
          end
        end
      end else begin
        push_word(3'($urandom), 3'($urandom), 8'($urandom), 1'($urandom), drain);
      end
      drain = ($urandom_range(199) == 0);
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Hold until every word is accepted and every result has arrived
    while (pending_words.size() != 0 || s_axis_tvalid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ interrupt_controller_8259.f @@
+incdir+hdl
hdl/pic8259_pkg.sv
hdl/pic8259_core.sv
hdl/interrupt_controller_8259.sv
hdl/pic8259_checker.sv
tb/sv/tb_top.sv
